@@ src/mcv_pkg.sv @@
// ----------------------------------------------------------------------------
// MQTT CONNECT validator package
// Payload types, error codes and configuration defaults shared by the block.
// ----------------------------------------------------------------------------
package mcv_pkg;

  localparam int IdLenWidth = 16;

  localparam logic [IdLenWidth-1:0] MAX_ID_LEN_DEFAULT = 16'd23;

  localparam logic [3:0] ERR_OK           = 4'd0;
  localparam logic [3:0] ERR_NAME_LEN     = 4'd1;
  localparam logic [3:0] ERR_NAME         = 4'd2;
  localparam logic [3:0] ERR_RESERVED     = 4'd3;
  localparam logic [3:0] ERR_WILL_FLAGS   = 4'd4;
  localparam logic [3:0] ERR_WILL_UNSUPP  = 4'd5;
  localparam logic [3:0] ERR_PROP_LEN     = 4'd6;
  localparam logic [3:0] ERR_BAD_PROP     = 4'd7;
  localparam logic [3:0] ERR_ID_LONG      = 4'd8;
  localparam logic [3:0] ERR_ID_CHAR      = 4'd9;
  localparam logic [3:0] ERR_LENGTH       = 4'd10;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_packet;
  } in_t;

  typedef struct packed {
    logic                  accepted;
    logic [3:0]            error_code;
    logic [7:0]            protocol_level;
    logic [15:0]           keep_alive_seconds;
    logic                  clean_start;
    logic                  has_username;
    logic                  has_password;
    logic [IdLenWidth-1:0] client_id_length;
  } out_t;

endpackage

@@ src/mcv_parser.sv @@
// ----------------------------------------------------------------------------
// MQTT CONNECT byte parser
// Per-byte state machine that walks the CONNECT header fields and builds the
// verdict when the last byte of a packet is taken.
// ----------------------------------------------------------------------------
module mcv_parser (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            take,
  input  mcv_pkg::in_t                    item,
  input  logic [mcv_pkg::IdLenWidth-1:0]  max_id_len,
  output logic                            result_valid,
  output mcv_pkg::out_t                   result
);

  localparam logic [4:0] PH_FH0       = 5'd0;
  localparam logic [4:0] PH_FH1       = 5'd1;
  localparam logic [4:0] PH_NL_HI     = 5'd2;
  localparam logic [4:0] PH_NL_LO     = 5'd3;
  localparam logic [4:0] PH_NAME0     = 5'd4;
  localparam logic [4:0] PH_NAME1     = 5'd5;
  localparam logic [4:0] PH_NAME2     = 5'd6;
  localparam logic [4:0] PH_NAME3     = 5'd7;
  localparam logic [4:0] PH_VERSION   = 5'd8;
  localparam logic [4:0] PH_FLAGS     = 5'd9;
  localparam logic [4:0] PH_KA_HI     = 5'd10;
  localparam logic [4:0] PH_KA_LO     = 5'd11;
  localparam logic [4:0] PH_PROP_LEN  = 5'd12;
  localparam logic [4:0] PH_PROP_ID   = 5'd13;
  localparam logic [4:0] PH_PROP_DATA = 5'd14;
  localparam logic [4:0] PH_ID_HI     = 5'd15;
  localparam logic [4:0] PH_ID_LO     = 5'd16;
  localparam logic [4:0] PH_ID_DATA   = 5'd17;
  localparam logic [4:0] PH_USER_HI   = 5'd18;
  localparam logic [4:0] PH_USER_LO   = 5'd19;
  localparam logic [4:0] PH_USER_DATA = 5'd20;
  localparam logic [4:0] PH_PASS_HI   = 5'd21;
  localparam logic [4:0] PH_PASS_LO   = 5'd22;
  localparam logic [4:0] PH_PASS_DATA = 5'd23;
  localparam logic [4:0] PH_DONE      = 5'd24;

  localparam logic [7:0] VERSION_5    = 8'd5;

  logic [4:0]  parse_phase;
  logic [15:0] field_countdown;
  logic [6:0]  property_bytes_left;
  logic [7:0]  length_high_byte;
  logic [3:0]  error_latch;
  logic [7:0]  version_reg;
  logic [15:0] keep_alive_reg;
  logic [7:0]  flags_reg;
  logic [15:0] id_length_reg;

  logic [4:0]  parse_phase_next;
  logic [15:0] field_countdown_next;
  logic [6:0]  property_bytes_left_next;
  logic [7:0]  length_high_byte_next;
  logic [3:0]  error_latch_next;
  logic [7:0]  version_reg_next;
  logic [15:0] keep_alive_reg_next;
  logic [7:0]  flags_reg_next;
  logic [15:0] id_length_reg_next;

  logic [7:0]  b;
  logic [15:0] len;
  logic [6:0]  prop_dec;
  logic [15:0] count_dec;
  logic [2:0]  prop_sz;
  logic [7:0]  name_char;
  logic [3:0]  final_err;

  function automatic logic [2:0] prop_size(input logic [7:0] id);
    logic [2:0] sz;
    case (id)
      8'h11:   sz = 3'd4;
      8'h21:   sz = 3'd2;
      8'h27:   sz = 3'd4;
      8'h22:   sz = 3'd2;
      8'h19:   sz = 3'd1;
      8'h17:   sz = 3'd1;
      default: sz = 3'd0;
    endcase
    return sz;
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic [4:0] after_username(input logic [7:0] flags);
    return flags[6] ? PH_PASS_HI : PH_DONE;
  endfunction

  function automatic logic [4:0] after_client_id(input logic [7:0] flags);
    return flags[7] ? PH_USER_HI : after_username(flags);
  endfunction

  assign b         = item.data_byte;
  assign len       = {length_high_byte, b};
  assign prop_dec  = property_bytes_left - 7'd1;
  assign count_dec = field_countdown - 16'd1;
  assign prop_sz   = prop_size(b);

  always_comb begin
    case (parse_phase[1:0])
      2'd0:    name_char = "M";
      2'd1:    name_char = "Q";
      default: name_char = "T";
    endcase
  end

  always_comb begin
    parse_phase_next         = parse_phase;
    field_countdown_next     = field_countdown;
    property_bytes_left_next = property_bytes_left;
    length_high_byte_next    = length_high_byte;
    error_latch_next         = error_latch;
    version_reg_next         = version_reg;
    keep_alive_reg_next      = keep_alive_reg;
    flags_reg_next           = flags_reg;
    id_length_reg_next       = id_length_reg;

    if (error_latch == mcv_pkg::ERR_OK) begin
      unique case (parse_phase)
        PH_FH0: parse_phase_next = PH_FH1;
        PH_FH1: parse_phase_next = PH_NL_HI;
        PH_NL_HI, PH_KA_HI, PH_ID_HI, PH_USER_HI, PH_PASS_HI: begin
          length_high_byte_next = b;
          parse_phase_next      = parse_phase + 5'd1;
        end
        PH_NL_LO: begin
          if (len != 16'd4) error_latch_next = mcv_pkg::ERR_NAME_LEN;
          else parse_phase_next = PH_NAME0;
        end
        PH_NAME0, PH_NAME1, PH_NAME2, PH_NAME3: begin
          if (b != name_char) error_latch_next = mcv_pkg::ERR_NAME;
          else parse_phase_next = parse_phase + 5'd1;
        end
        PH_VERSION: begin
          version_reg_next = b;
          parse_phase_next = PH_FLAGS;
        end
        PH_FLAGS: begin
          flags_reg_next = b;
          if (b[0]) error_latch_next = mcv_pkg::ERR_RESERVED;
          else if (!b[2]) begin
            if ((b & 8'h38) != 8'h00) error_latch_next = mcv_pkg::ERR_WILL_FLAGS;
            else parse_phase_next = PH_KA_HI;
          end else if ((b & 8'h18) == 8'h18) error_latch_next = mcv_pkg::ERR_WILL_FLAGS;
          else error_latch_next = mcv_pkg::ERR_WILL_UNSUPP;
        end
        PH_KA_LO: begin
          keep_alive_reg_next = len;
          parse_phase_next    = (version_reg == VERSION_5) ? PH_PROP_LEN : PH_ID_HI;
        end
        PH_PROP_LEN: begin
          if (b[7]) error_latch_next = mcv_pkg::ERR_PROP_LEN;
          else begin
            property_bytes_left_next = b[6:0];
            parse_phase_next = (b[6:0] != 7'd0) ? PH_PROP_ID : PH_ID_HI;
          end
        end
        PH_PROP_ID: begin
          property_bytes_left_next = prop_dec;
          if (prop_sz == 3'd0) error_latch_next = mcv_pkg::ERR_BAD_PROP;
          else if ({4'd0, prop_sz} > prop_dec) error_latch_next = mcv_pkg::ERR_PROP_LEN;
          else begin
            field_countdown_next = {13'd0, prop_sz};
            parse_phase_next     = PH_PROP_DATA;
          end
        end
        PH_PROP_DATA: begin
          field_countdown_next     = count_dec;
          property_bytes_left_next = prop_dec;
          if (count_dec == 16'd0) begin
            parse_phase_next = (prop_dec != 7'd0) ? PH_PROP_ID : PH_ID_HI;
          end
        end
        PH_ID_LO: begin
          id_length_reg_next = len;
          if (len > max_id_len) error_latch_next = mcv_pkg::ERR_ID_LONG;
          else if (len == 16'd0) parse_phase_next = after_client_id(flags_reg);
          else begin
            field_countdown_next = len;
            parse_phase_next     = PH_ID_DATA;
          end
        end
        PH_ID_DATA: begin
          if (!is_alnum(b)) error_latch_next = mcv_pkg::ERR_ID_CHAR;
          else begin
            field_countdown_next = count_dec;
            if (count_dec == 16'd0) parse_phase_next = after_client_id(flags_reg);
          end
        end
        PH_USER_LO: begin
          if (len == 16'd0) parse_phase_next = after_username(flags_reg);
          else begin
            field_countdown_next = len;
            parse_phase_next     = PH_USER_DATA;
          end
        end
        PH_USER_DATA: begin
          field_countdown_next = count_dec;
          if (count_dec == 16'd0) parse_phase_next = after_username(flags_reg);
        end
        PH_PASS_LO: begin
          if (len == 16'd0) parse_phase_next = PH_DONE;
          else begin
            field_countdown_next = len;
            parse_phase_next     = PH_PASS_DATA;
          end
        end
        PH_PASS_DATA: begin
          field_countdown_next = count_dec;
          if (count_dec == 16'd0) parse_phase_next = PH_DONE;
        end
        default: error_latch_next = mcv_pkg::ERR_LENGTH;
      endcase
    end
  end

  always_comb begin
    final_err = error_latch_next;
    if (error_latch_next == mcv_pkg::ERR_OK && parse_phase_next != PH_DONE) begin
      final_err = mcv_pkg::ERR_LENGTH;
    end
  end

  assign result_valid              = take && item.end_of_packet;
  assign result.accepted           = (final_err == mcv_pkg::ERR_OK);
  assign result.error_code         = final_err;
  assign result.protocol_level     = version_reg_next;
  assign result.keep_alive_seconds = keep_alive_reg_next;
  assign result.clean_start        = flags_reg_next[1];
  assign result.has_username       = flags_reg_next[7];
  assign result.has_password       = flags_reg_next[6];
  assign result.client_id_length   = id_length_reg_next;

  always_ff @(posedge clk) begin
    if (rst || (take && item.end_of_packet)) begin
      parse_phase         <= PH_FH0;
      field_countdown     <= '0;
      property_bytes_left <= '0;
      length_high_byte    <= '0;
      error_latch         <= mcv_pkg::ERR_OK;
      version_reg         <= '0;
      keep_alive_reg      <= '0;
      flags_reg           <= '0;
      id_length_reg       <= '0;
    end else if (take) begin
      parse_phase         <= parse_phase_next;
      field_countdown     <= field_countdown_next;
      property_bytes_left <= property_bytes_left_next;
      length_high_byte    <= length_high_byte_next;
      error_latch         <= error_latch_next;
      version_reg         <= version_reg_next;
      keep_alive_reg      <= keep_alive_reg_next;
      flags_reg           <= flags_reg_next;
      id_length_reg       <= id_length_reg_next;
    end
  end

endmodule

@@ src/mcv_out_buf.sv @@
// ----------------------------------------------------------------------------
// MQTT CONNECT validator result buffer
// Two-entry output register with skid stage for the verdict words.
// ----------------------------------------------------------------------------
module mcv_out_buf (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  mcv_pkg::out_t push_data,
  output logic          space,
  output logic          out_valid,
  input  logic          out_ready,
  output mcv_pkg::out_t out_data
);

  logic          head_valid;
  logic          skid_valid;
  mcv_pkg::out_t head_data;
  mcv_pkg::out_t skid_data;

  logic          head_valid_next;
  logic          skid_valid_next;
  mcv_pkg::out_t head_data_next;
  mcv_pkg::out_t skid_data_next;
  logic          pop;

  assign pop       = head_valid && out_ready;
  assign space     = !skid_valid;
  assign out_valid = head_valid;
  assign out_data  = head_data;

  always_comb begin
    head_valid_next = head_valid;
    skid_valid_next = skid_valid;
    head_data_next  = head_data;
    skid_data_next  = skid_data;
    if (pop) begin
      if (skid_valid) begin
        head_data_next  = skid_data;
        skid_valid_next = push;
        skid_data_next  = push_data;
      end else begin
        head_valid_next = push;
        head_data_next  = push_data;
      end
    end else if (push) begin
      if (!head_valid) begin
        head_valid_next = 1'b1;
        head_data_next  = push_data;
      end else begin
        skid_valid_next = 1'b1;
        skid_data_next  = push_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      head_valid <= head_valid_next;
      skid_valid <= skid_valid_next;
    end
    head_data <= head_data_next;
    skid_data <= skid_data_next;
  end

endmodule

@@ src/mqtt_connect_validator.sv @@
// ----------------------------------------------------------------------------
// MQTT CONNECT validator
// Checks one CONNECT packet, one byte per word, and returns one verdict word
// when the word marked as the end of the packet has been taken.
//
//   Channel   Signals                              Direction
//   in        in_valid, in_ready, in_data          packet bytes in
//   out       out_valid, out_ready, out_data       verdict words out
//   cfg       cfg_we, cfg_data                     client ID length limit
//
// One word is taken every cycle while the buffer has space; the byte state
// machine updates on each taken word. A verdict word enters the result
// buffer when its end word is taken and is shown once earlier verdicts leave.
// A two-entry result buffer keeps input flowing while a verdict waits; input
// stalls only when both entries are full.
// Reset is synchronous and sets the limit to 23 and the parser to its start.
// ----------------------------------------------------------------------------
module mqtt_connect_validator (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  mcv_pkg::in_t                   in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output mcv_pkg::out_t                  out_data,
  input  logic                           cfg_we,
  input  logic [mcv_pkg::IdLenWidth-1:0] cfg_data
);

  logic [mcv_pkg::IdLenWidth-1:0] max_client_id_length;
  logic                           take;
  logic                           result_valid;
  mcv_pkg::out_t                  result;

  assign take = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_client_id_length <= mcv_pkg::MAX_ID_LEN_DEFAULT;
    end else if (cfg_we) begin
      max_client_id_length <= cfg_data;
    end
  end

  mcv_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .take         (take),
    .item         (in_data),
    .max_id_len   (max_client_id_length),
    .result_valid (result_valid),
    .result       (result)
  );

  mcv_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (result_valid),
    .push_data (result),
    .space     (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("Input stalled while no verdict is pending.");

  a_accept_matches_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.accepted == (out_data.error_code == mcv_pkg::ERR_OK)))
    else $error("Accepted flag disagrees with the error code.");

  a_code_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.error_code <= mcv_pkg::ERR_LENGTH))
    else $error("Error code out of range.");

  a_limit_reset: assert property (@(posedge clk)
    rst |=> (max_client_id_length == mcv_pkg::MAX_ID_LEN_DEFAULT))
    else $error("Client ID limit not restored by reset.");

endmodule
